@@ hw/rtl/aacm_pkg.sv @@
`default_nettype none

package aacm_pkg;

	localparam int OP_W = 2;
	localparam int ROW_W = 10;
	localparam int WIDX_W = 4;
	localparam int WORD_W = 64;
	localparam int ANC_W = 10;
	localparam int MAX_TBL_ROWS = 1 << ROW_W;
	localparam int MAX_TBL_COLS = 1 << WIDX_W;
	localparam int BIT_SEL_W = 6;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE = 3'b010,
		S_LOOK = 3'b100
	} state_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_read;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/aacm_ctrl.sv @@
`default_nettype none

module aacm_ctrl
	import aacm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire status_t sts,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE) || sts.out_busy;

	always_comb begin
		cmd.clr = (state_q == S_CLEAR);
		cmd.take = req_valid && !req_stall;
		cmd.finish = (state_q == S_LOOK);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.take && sts.op_read) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/aacm_dp.sv @@
`default_nettype none

module aacm_dp
	import aacm_pkg::*;
#(
	parameter int CLASS_COUNT = 1024,
	parameter int SCORE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	output status_t                           sts,
	input  wire logic [OP_W-1:0]              opcode,
	input  wire logic [ROW_W-1:0]             table_row,
	input  wire logic [WIDX_W-1:0]            table_word_index,
	input  wire logic [WORD_W-1:0]            table_word,
	input  wire logic signed [SCORE_BITS-1:0] score,
	input  wire logic                         score_last,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              result_kind,
	output logic                              anchor_found,
	output logic [ANC_W-1:0]                  anchor_class,
	output logic signed [SCORE_BITS-1:0]      filtered_score,
	output logic                              read_last
);

	localparam int CLS_W = $clog2(CLASS_COUNT);
	localparam int CNT_W = $clog2(CLASS_COUNT + 1);
	localparam int ROW_WORDS = CLASS_COUNT / WORD_W;
	localparam int TBL_ROWS = (CLASS_COUNT < MAX_TBL_ROWS) ? CLASS_COUNT : MAX_TBL_ROWS;
	localparam int TBL_COLS = (ROW_WORDS < MAX_TBL_COLS) ? ROW_WORDS : MAX_TBL_COLS;
	localparam int RW = $clog2(TBL_ROWS);
	localparam int CW = (TBL_COLS > 1) ? $clog2(TBL_COLS) : 1;
	localparam int TADDR_W = RW + CW;
	localparam int TBL_DEPTH = 1 << TADDR_W;
	localparam logic signed [SCORE_BITS-1:0] MINUS_ONE = {2'b11, {(SCORE_BITS - 2){1'b0}}};

	logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
	logic signed [SCORE_BITS-1:0] buf_mem [CLASS_COUNT];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rptr_q;
	logic signed [SCORE_BITS-1:0] max_q;
	logic [CLS_W-1:0] anchor_q;
	logic anchor_vld_q;
	logic vec_done_q;
	logic [TADDR_W-1:0] clr_q;

	logic [WORD_W-1:0] tbl_rd_s1;
	logic signed [SCORE_BITS-1:0] buf_rd_s1;
	logic rng_s1;
	logic last_s1;
	logic self_s1;
	logic tok_s1;
	logic [BIT_SEL_W-1:0] bit_s1;

	logic out_valid_q;
	logic out_kind_q;
	logic out_found_q;
	logic [ANC_W-1:0] out_class_q;
	logic signed [SCORE_BITS-1:0] out_score_q;
	logic out_last_q;

	logic is_write;
	logic is_push;
	logic is_read;
	logic [CNT_W-1:0] eff_cnt;
	logic signed [SCORE_BITS-1:0] eff_max;
	logic [CLS_W-1:0] eff_anc;
	logic eff_vld;
	logic room;
	logic greater;
	logic [CLS_W-1:0] new_anc;
	logic new_vld;
	logic [CLS_W+ANC_W-1:0] new_anc_ext;
	logic [CLS_W+ANC_W-1:0] cur_anc_ext;
	logic tbl_we;
	logic [TADDR_W-1:0] tbl_waddr;
	logic [WORD_W-1:0] tbl_wdata;
	logic [TADDR_W-1:0] tbl_raddr;
	logic [CNT_W-1:0] rcol;
	logic rd_rng;
	logic allowed;
	logic masked;

	assign is_write = cmd.take && (opcode == OP_WRITE);
	assign is_push = cmd.take && (opcode == OP_PUSH);
	assign is_read = cmd.take && (opcode == OP_READ);

	always_comb begin
		sts.clr_last = (clr_q == {TADDR_W{1'b1}});
		sts.op_read = (opcode == OP_READ);
		sts.out_busy = out_valid_q && rsp_stall;
	end

	always_comb begin
		eff_cnt = vec_done_q ? '0 : count_q;
		eff_max = vec_done_q ? MINUS_ONE : max_q;
		eff_anc = vec_done_q ? '0 : anchor_q;
		eff_vld = vec_done_q ? 1'b0 : anchor_vld_q;
		room = (eff_cnt < CNT_W'(CLASS_COUNT));
		greater = room && (score > eff_max);
		new_anc = greater ? eff_cnt[CLS_W-1:0] : eff_anc;
		new_vld = greater || eff_vld;
		new_anc_ext = {{ANC_W{1'b0}}, new_anc};
		cur_anc_ext = {{ANC_W{1'b0}}, anchor_q};
	end

	always_comb begin
		tbl_we = 1'b0;
		tbl_waddr = {table_row[RW-1:0], table_word_index[CW-1:0]};
		tbl_wdata = table_word;
		if (cmd.clr) begin
			tbl_we = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '0;
		end else if (is_write && ({1'b0, table_row} < (ROW_W + 1)'(TBL_ROWS))
				&& ({1'b0, table_word_index} < (WIDX_W + 1)'(TBL_COLS))) begin
			tbl_we = 1'b1;
		end
	end

	always_comb begin
		rcol = rptr_q >> BIT_SEL_W;
		tbl_raddr = {anchor_q[RW-1:0], rcol[CW-1:0]};
		rd_rng = (rptr_q < count_q);
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rd_s1 <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (is_push && room) begin
			buf_mem[eff_cnt[CLS_W-1:0]] <= score;
		end
		buf_rd_s1 <= buf_mem[rptr_q[CLS_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rng_s1 <= rd_rng;
			last_s1 <= ((rptr_q + CNT_W'(1)) == count_q);
			self_s1 <= (CNT_W'(anchor_q) == rptr_q);
			tok_s1 <= (CNT_W'(anchor_q) < CNT_W'(TBL_ROWS)) && (rcol < CNT_W'(TBL_COLS));
			bit_s1 <= rptr_q[BIT_SEL_W-1:0];
		end
	end

	always_comb begin
		allowed = self_s1 || (tok_s1 && tbl_rd_s1[bit_s1]);
		masked = anchor_vld_q && !allowed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			count_q <= '0;
			rptr_q <= '0;
			max_q <= MINUS_ONE;
			anchor_q <= '0;
			anchor_vld_q <= 1'b0;
			vec_done_q <= 1'b1;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + TADDR_W'(1);
			end
			if (is_push) begin
				count_q <= room ? eff_cnt + CNT_W'(1) : eff_cnt;
				max_q <= greater ? score : eff_max;
				anchor_q <= new_anc;
				anchor_vld_q <= new_vld;
				vec_done_q <= score_last;
				rptr_q <= (score_last || vec_done_q) ? '0 : rptr_q;
			end else if (is_read && rd_rng) begin
				rptr_q <= rptr_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((is_push && score_last) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_push && score_last) begin
			out_kind_q <= KIND_REPORT;
			out_found_q <= new_vld;
			out_class_q <= new_vld ? new_anc_ext[ANC_W-1:0] : '0;
			out_score_q <= '0;
			out_last_q <= 1'b0;
		end else if (cmd.finish) begin
			out_kind_q <= KIND_READ;
			out_found_q <= anchor_vld_q;
			out_class_q <= anchor_vld_q ? cur_anc_ext[ANC_W-1:0] : '0;
			out_score_q <= (rng_s1 && !masked) ? buf_rd_s1 : '0;
			out_last_q <= rng_s1 ? last_s1 : 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign anchor_found = out_found_q;
	assign anchor_class = out_class_q;
	assign filtered_score = out_score_q;
	assign read_last = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/argmax_anchor_class_mask.sv @@
// Anchor-class score filter. After reset the block sweeps its compatibility table to zero, one
// 64-bit word per cycle, and holds req_stall high meanwhile. Table writes and score pushes
// do not take the controller out of its idle state; a read moves it into a look-up state,
// which stalls the request side, because the score buffer and the table are read through
// registered memory ports before the masking decision.
// A push with score_last produces an anchor report in the output register, and each read
// produces one filtered score. The request side stalls while an undelivered result is held back
// by rsp_stall.
`default_nettype none

module argmax_anchor_class_mask
	import aacm_pkg::*;
#(
	parameter int CLASS_COUNT = 1024,
	parameter int SCORE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [OP_W-1:0]              opcode,
	input  wire logic [ROW_W-1:0]             table_row,
	input  wire logic [WIDX_W-1:0]            table_word_index,
	input  wire logic [WORD_W-1:0]            table_word,
	input  wire logic signed [SCORE_BITS-1:0] score,
	input  wire logic                         score_last,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              result_kind,
	output logic                              anchor_found,
	output logic [ANC_W-1:0]                  anchor_class,
	output logic signed [SCORE_BITS-1:0]      filtered_score,
	output logic                              read_last
);

	cmd_t cmd;
	status_t sts;

	aacm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	aacm_dp #(
		.CLASS_COUNT (CLASS_COUNT),
		.SCORE_BITS  (SCORE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.opcode           (opcode),
		.table_row        (table_row),
		.table_word_index (table_word_index),
		.table_word       (table_word),
		.score            (score),
		.score_last       (score_last),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.result_kind      (result_kind),
		.anchor_found     (anchor_found),
		.anchor_class     (anchor_class),
		.filtered_score   (filtered_score),
		.read_last        (read_last)
	);

endmodule

`default_nettype wire

@@ dv/argmax_anchor_class_mask_checker.sv @@
`timescale 1ns / 1ps

module argmax_anchor_class_mask_checker
	import aacm_pkg::*;
#(
	parameter int CLASS_COUNT = 1024,
	parameter int SCORE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic [OP_W-1:0]              opcode,
	input  logic [ROW_W-1:0]             table_row,
	input  logic [WIDX_W-1:0]            table_word_index,
	input  logic [WORD_W-1:0]            table_word,
	input  logic signed [SCORE_BITS-1:0] score,
	input  logic                         score_last,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic                         result_kind,
	input  logic                         anchor_found,
	input  logic [ANC_W-1:0]             anchor_class,
	input  logic signed [SCORE_BITS-1:0] filtered_score,
	input  logic                         read_last,
	output int                           errors,
	output int                           outstanding,
	output int                           checked,
	output int                           masked
);

	localparam int ROW_WORDS = CLASS_COUNT / 64;
	localparam logic signed [SCORE_BITS-1:0] MINUS_ONE = SCORE_BITS'(-(1 <<< (SCORE_BITS - 2)));

	typedef struct packed {
		logic                         kind;
		logic                         found;
		logic [ANC_W-1:0]             cls;
		logic signed [SCORE_BITS-1:0] val;
		logic                         last;
	} filt_t;

	logic [WORD_W-1:0] compat [CLASS_COUNT][ROW_WORDS];
	logic signed [SCORE_BITS-1:0] stored [CLASS_COUNT];
	logic [10:0] stored_count;
	logic [10:0] read_ptr;
	logic signed [SCORE_BITS-1:0] best_score;
	logic [ANC_W-1:0] anchor;
	logic anchor_ok;
	logic vector_done;
	filt_t due_results [$];
	filt_t want;

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		errors++;
		if (errors <= 100)
			$display("%0t: %s: expected %0h, got %0h", $time, what, exp_v, got_v);
	endtask

	function automatic void advance_filter(input logic [OP_W-1:0] op,
		input logic [ROW_W-1:0] row, input logic [WIDX_W-1:0] widx,
		input logic [WORD_W-1:0] word, input logic signed [SCORE_BITS-1:0] sc,
		input logic last);
		filt_t r;
		logic signed [SCORE_BITS-1:0] v;
		r = '0;
		case (op)
			OP_WRITE: begin
				if (row < CLASS_COUNT && widx < ROW_WORDS)
					compat[row][widx] = word;
			end
			OP_PUSH: begin
				if (vector_done) begin
					stored_count = '0;
					read_ptr = '0;
					best_score = MINUS_ONE;
					anchor = '0;
					anchor_ok = 1'b0;
					vector_done = 1'b0;
				end
				if (stored_count < CLASS_COUNT) begin
					stored[stored_count] = sc;
					if (sc > best_score) begin
						best_score = sc;
						anchor = stored_count[ANC_W-1:0];
						anchor_ok = 1'b1;
					end
					stored_count++;
				end
				if (last) begin
					vector_done = 1'b1;
					read_ptr = '0;
					r.kind = KIND_REPORT;
					r.found = anchor_ok;
					r.cls = anchor_ok ? anchor : '0;
					due_results.push_back(r);
				end
			end
			OP_READ: begin
				r.kind = KIND_READ;
				r.found = anchor_ok;
				r.cls = anchor_ok ? anchor : '0;
				if (read_ptr < stored_count) begin
					v = stored[read_ptr];
					if (anchor_ok && anchor != read_ptr[ANC_W-1:0]
						&& !compat[anchor][read_ptr[9:6]][read_ptr[5:0]]) begin
						v = '0;
						masked++;
					end
					r.val = v;
					r.last = (read_ptr + 11'd1 == stored_count);
					read_ptr++;
				end else begin
					r.val = '0;
					r.last = 1'b1;
				end
				due_results.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < CLASS_COUNT; r++)
				for (int w = 0; w < ROW_WORDS; w++)
					compat[r][w] = '0;
			stored_count = '0;
			read_ptr = '0;
			best_score = MINUS_ONE;
			anchor = '0;
			anchor_ok = 1'b0;
			vector_done = 1'b1;
			due_results.delete();
			errors = 0;
			checked = 0;
			masked = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing pending, kind", '0,
						64'(result_kind));
				end else begin
					want = due_results.pop_front();
					checked++;
					if (result_kind !== want.kind)
						report_mismatch("result_kind", 64'(want.kind), 64'(result_kind));
					if (anchor_found !== want.found)
						report_mismatch("anchor_found", 64'(want.found), 64'(anchor_found));
					if (anchor_class !== want.cls)
						report_mismatch("anchor_class", 64'(want.cls), 64'(anchor_class));
					if (filtered_score !== want.val)
						report_mismatch("filtered_score", 64'(want.val),
							64'(filtered_score));
					if (read_last !== want.last)
						report_mismatch("read_last", 64'(want.last), 64'(read_last));
				end
			end
			if (req_valid && !req_stall)
				advance_filter(opcode, table_row, table_word_index, table_word, score,
					score_last);
			outstanding <= due_results.size();
		end
	end

endmodule

@@ dv/tb_argmax_anchor_class_mask.sv @@
`timescale 1ns / 1ps

module tb_argmax_anchor_class_mask;
	import aacm_pkg::*;

	localparam int CLASS_COUNT = 1024;
	localparam int SCORE_BITS = 16;
	localparam int LIMIT = 500000;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef enum int {MIX_FULL, MIX_LOW, MIX_EDGE, MIX_TIES} mix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [OP_W-1:0] opcode;
	logic [ROW_W-1:0] table_row;
	logic [WIDX_W-1:0] table_word_index;
	logic [WORD_W-1:0] table_word;
	logic signed [SCORE_BITS-1:0] score;
	logic score_last;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic result_kind;
	logic anchor_found;
	logic [ANC_W-1:0] anchor_class;
	logic signed [SCORE_BITS-1:0] filtered_score;
	logic read_last;

	int fail_count;
	int outstanding;
	int checked;
	int masked;
	int cycles = 0;
	int rsp_wait = 0;
	int rsp_draw;
	bit calm = 1'b0;
	int n_writes = 0;
	int n_pushes = 0;
	int n_reads = 0;
	int n_vectors = 0;

	always #5 clk = ~clk;

	argmax_anchor_class_mask #(
		.CLASS_COUNT(CLASS_COUNT),
		.SCORE_BITS(SCORE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.table_row(table_row),
		.table_word_index(table_word_index),
		.table_word(table_word),
		.score(score),
		.score_last(score_last),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_kind(result_kind),
		.anchor_found(anchor_found),
		.anchor_class(anchor_class),
		.filtered_score(filtered_score),
		.read_last(read_last)
	);

	argmax_anchor_class_mask_checker #(
		.CLASS_COUNT(CLASS_COUNT),
		.SCORE_BITS(SCORE_BITS)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.table_row(table_row),
		.table_word_index(table_word_index),
		.table_word(table_word),
		.score(score),
		.score_last(score_last),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_kind(result_kind),
		.anchor_found(anchor_found),
		.anchor_class(anchor_class),
		.filtered_score(filtered_score),
		.read_last(read_last),
		.errors(fail_count),
		.outstanding(outstanding),
		.checked(checked),
		.masked(masked)
	);

	always @(posedge clk) begin
		if (rsp_wait > 0) begin
			rsp_wait <= rsp_wait - 1;
			if (rsp_wait == 1)
				rsp_stall <= 1'b0;
		end else if (rsp_valid && !rsp_stall) begin
			rsp_draw = calm ? 0 : $urandom_range(0, 14);
			if (rsp_draw > 0) begin
				rsp_stall <= 1'b1;
				rsp_wait <= rsp_draw;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Timed out after %0d cycles with %0d results pending.", LIMIT,
				outstanding);
			$display("tb_argmax_anchor_class_mask: FAIL");
			$finish;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
		input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] word,
		input logic signed [SCORE_BITS-1:0] sc, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		table_row <= row;
		table_word_index <= widx;
		table_word <= word;
		score <= sc;
		score_last <= last;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic write_word(input logic [ROW_W-1:0] row, input logic [WIDX_W-1:0] widx,
		input logic [WORD_W-1:0] word);
		send(OP_WRITE, row, widx, word, SCORE_BITS'($urandom), 1'($urandom));
		n_writes++;
	endtask

	task automatic push_score(input logic signed [SCORE_BITS-1:0] sc, input logic last);
		send(OP_PUSH, ROW_W'($urandom), WIDX_W'($urandom), {$urandom, $urandom}, sc, last);
		n_pushes++;
		if (last)
			n_vectors++;
	endtask

	task automatic read_one();
		send(OP_READ, ROW_W'($urandom), WIDX_W'($urandom), {$urandom, $urandom},
			SCORE_BITS'($urandom), 1'($urandom));
		n_reads++;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: rand_word = '1;
			1: rand_word = '0;
			default: rand_word = {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int i;
		int len;
		int nrd;
		int spot;
		int start_items;
		mix_t mix;
		logic [OP_W-1:0] op;
		logic signed [SCORE_BITS-1:0] s;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		opcode <= OP_WRITE;
		table_row <= '0;
		table_word_index <= '0;
		table_word <= '0;
		score <= '0;
		score_last <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing loaded yet: the read lands past the end with no anchor.
		read_one();
		send(OP_NONE, '1, '1, '1, '1, 1'b1);
		write_word(10'd1023, 4'd15, '1);
		write_word(10'd0, 4'd0, '0);
		write_word(10'd1, 4'd0, 64'h5);
		write_word(10'd512, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);

		// No score rises above -1.0, including one sitting exactly on it.
		push_score(16'sh8000, 1'b0);
		push_score(16'shC000, 1'b0);
		read_one();
		push_score(16'shC000, 1'b1);
		repeat (4) read_one();

		// Just above -1.0, then a tie at the top where the first one wins.
		push_score(16'shC001, 1'b0);
		push_score(16'sh7FFF, 1'b0);
		push_score(16'sh7FFF, 1'b0);
		push_score(16'sd1234, 1'b1);
		repeat (5) read_one();

		// One vector overflows the score buffer; the extra pushes must not be kept.
		spot = $urandom_range(512, CLASS_COUNT - 1);
		for (i = 0; i < CLASS_COUNT / 64; i++)
			write_word(spot[ROW_W-1:0], i[WIDX_W-1:0], rand_word());
		for (i = 0; i < CLASS_COUNT + 3; i++) begin
			if (i == spot)
				s = 16'sh7FFE;
			else if (i >= CLASS_COUNT)
				s = 16'sh7FFF;
			else
				s = SCORE_BITS'($urandom_range(0, 64768) - 32768);
			push_score(s, i == CLASS_COUNT + 2);
		end
		repeat (CLASS_COUNT + 2) read_one();

		start_items = n_writes + n_pushes + n_reads;
		while (n_writes + n_pushes + n_reads < start_items + 500) begin
			if ($urandom_range(0, 6) == 0)
				calm = ~calm;
			if ($urandom_range(0, 3) == 0) begin
				op = OP_W'($urandom_range(0, 3));
				case (op)
					OP_WRITE: write_word(ROW_W'($urandom), WIDX_W'($urandom), rand_word());
					OP_PUSH: push_score(SCORE_BITS'($urandom), 1'($urandom));
					OP_READ: read_one();
					default: send(OP_NONE, ROW_W'($urandom), WIDX_W'($urandom), rand_word(),
						SCORE_BITS'($urandom), 1'($urandom));
				endcase
			end else begin
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 4) == 0)
						write_word(ROW_W'($urandom), WIDX_W'($urandom), rand_word());
					else
						write_word(ROW_W'($urandom_range(0, 39)), '0, rand_word());
				end
				len = $urandom_range(1, 40);
				mix = mix_t'($urandom_range(0, 3));
				for (i = 0; i < len; i++) begin
					case (mix)
						MIX_FULL: s = SCORE_BITS'($urandom);
						MIX_LOW: s = SCORE_BITS'($urandom_range(0, 16384) - 32768);
						MIX_EDGE: s = SCORE_BITS'($urandom_range(0, 4) - 16386);
						default: s = SCORE_BITS'(100 * $urandom_range(1, 3));
					endcase
					if ($urandom_range(0, 15) == 0)
						read_one();
					push_score(s, i == len - 1);
				end
				if ($urandom_range(0, 4) == 0)
					nrd = $urandom_range(0, len + 2);
				else
					nrd = len + $urandom_range(0, 2);
				repeat (nrd) read_one();
			end
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		$display("Covered %0d table writes, %0d score pushes in %0d vectors and %0d reads,",
			n_writes, n_pushes, n_vectors, n_reads);
		$display("with one vector overflowing the buffer; %0d results checked, %0d masked.",
			checked, masked);
		if (fail_count == 0)
			$display("tb_argmax_anchor_class_mask: PASS");
		else
			$display("tb_argmax_anchor_class_mask: FAIL");
		$finish;
	end

endmodule
